// ===== rtl/ftes_pkg.sv =====
// Shared types, constants and calendar helpers for the frame timestamp converter.
package ftes_pkg;

  localparam int unsigned OUT_W = 42;
  localparam int unsigned DAYS_W = 27;
  localparam int unsigned HMS_W = 20;

  localparam logic [15:0] EPOCH_YEAR = 16'd1970;
  // Leap years in [0, 1970)
  localparam logic signed [15:0] LEAPS_BEFORE_EPOCH = 16'sd478;
  localparam logic signed [17:0] SECS_PER_DAY = 18'sd86400;

  // Reciprocal of 25 scaled by 2^19, exact for inputs below 2^14
  localparam logic [14:0] RECIP_25 = 15'd20972;
  localparam int unsigned RECIP_SHIFT = 19;

  // Timestamp bytes snapshot at the seconds byte
  typedef struct packed {
    logic [15:0] year;
    logic [7:0]  month;
    logic [7:0]  day;
    logic [7:0]  hour;
    logic [7:0]  minute;
    logic [7:0]  second;
  } ts_t;

  // Floor of x / 25 for a 14-bit value
  function automatic logic [9:0] div25(input logic [13:0] x);
    logic [28:0] prod;
    prod = {15'd0, x} * {14'd0, RECIP_25};
    return prod[28:RECIP_SHIFT];
  endfunction

  // Days in the completed months of a non-leap year
  function automatic logic [8:0] cum_days(input logic [3:0] done);
    logic [8:0] d;
    case (done)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd365;
    endcase
    return d;
  endfunction

endpackage

// ===== rtl/frame_timestamp_to_epoch_seconds.sv =====
// Top level: frame byte counter, timestamp capture and epoch pipeline.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------
//  input   | in_valid / in_stall  | data_byte, frame_start
//  output  | out_valid / out_stall| epoch_seconds (42b signed)
//
// One byte is taken per cycle while in_stall is low. The seconds byte loads the
// snapshot register, and its result then passes the year-term, day-count and
// day-to-second scaling stages before it is presented.
// Synchronous reset clears the byte position, captured bytes and pipeline valid flags.
// A stalled output holds the pipeline; input stalls only once all four
// stages hold a transaction.
module frame_timestamp_to_epoch_seconds import ftes_pkg::*; #(
  parameter int unsigned TIME_OFFSET = 10
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic [7:0]              data_byte,
  input  logic                    frame_start,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] epoch_seconds
);

  localparam int unsigned POS_W = $clog2(TIME_OFFSET + 9);
  localparam logic [POS_W-1:0] POS_YEAR_HI = POS_W'(TIME_OFFSET);
  localparam logic [POS_W-1:0] POS_YEAR_LO = POS_W'(TIME_OFFSET + 1);
  localparam logic [POS_W-1:0] POS_MONTH   = POS_W'(TIME_OFFSET + 2);
  localparam logic [POS_W-1:0] POS_DAY     = POS_W'(TIME_OFFSET + 3);
  localparam logic [POS_W-1:0] POS_HOUR    = POS_W'(TIME_OFFSET + 5);
  localparam logic [POS_W-1:0] POS_MINUTE  = POS_W'(TIME_OFFSET + 6);
  localparam logic [POS_W-1:0] POS_SECOND  = POS_W'(TIME_OFFSET + 7);
  localparam logic [POS_W-1:0] POS_DONE    = POS_W'(TIME_OFFSET + 8);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] pos;
  logic [15:0]      captured_year;
  logic [7:0]       captured_month;
  logic [7:0]       captured_day;
  logic [7:0]       captured_hour;
  logic [7:0]       captured_minute;
  logic             accept;
  logic             calc_ready;
  logic             calc_load;
  ts_t              ts;

  assign in_stall = !calc_ready;
  assign accept = in_valid && calc_ready;
  assign pos = frame_start ? '0 : byte_position;
  assign calc_load = accept && (pos == POS_SECOND);

  // Snapshot handed to the pipeline with the seconds byte
  always_comb begin
    ts.year   = captured_year;
    ts.month  = captured_month;
    ts.day    = captured_day;
    ts.hour   = captured_hour;
    ts.minute = captured_minute;
    ts.second = data_byte;
  end

  // Count byte positions and capture timestamp bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position   <= '0;
      captured_year   <= '0;
      captured_month  <= '0;
      captured_day    <= '0;
      captured_hour   <= '0;
      captured_minute <= '0;
    end else if (accept) begin
      if (pos < POS_DONE) begin
        byte_position <= pos + POS_W'(1);
      end else begin
        byte_position <= pos;
      end
      if (pos == POS_YEAR_HI) begin
        captured_year[15:8] <= data_byte;
      end
      if (pos == POS_YEAR_LO) begin
        captured_year[7:0] <= data_byte;
      end
      if (pos == POS_MONTH) begin
        captured_month <= data_byte;
      end
      if (pos == POS_DAY) begin
        captured_day <= data_byte;
      end
      if (pos == POS_HOUR) begin
        captured_hour <= data_byte;
      end
      if (pos == POS_MINUTE) begin
        captured_minute <= data_byte;
      end
    end
  end

  ftes_calc u_calc (
    .clk           (clk),
    .rst           (rst),
    .load          (calc_load),
    .ts            (ts),
    .ready         (calc_ready),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .epoch_seconds (epoch_seconds)
  );

endmodule

// ===== rtl/ftes_calc.sv =====
// Four-stage pipeline turning a captured timestamp into seconds since 1970.
module ftes_calc import ftes_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    load,
  input  ts_t                     ts,
  output logic                    ready,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic signed [OUT_W-1:0] epoch_seconds
);

  // Stage 1: snapshot
  logic s1_valid;
  ts_t  s1;

  // Stage 2: year terms and month index
  logic                     s2_valid;
  logic signed [DAYS_W-1:0] s2_year_days;
  logic signed [15:0]       s2_leap_diff;
  logic                     s2_leap_adj;
  logic [3:0]               s2_done;
  logic [7:0]               s2_day;
  logic [7:0]               s2_hour;
  logic [7:0]               s2_minute;
  logic [7:0]               s2_second;

  // Stage 3: day count and time of day
  logic                     s3_valid;
  logic signed [DAYS_W-1:0] s3_days;
  logic [HMS_W-1:0]         s3_hms;

  // Stage 4: result register
  logic s4_valid;

  logic s1_ready;
  logic s2_ready;
  logic s3_ready;
  logic s4_ready;

  // Each stage moves when the one after it has room
  assign s4_ready = !s4_valid || !out_stall;
  assign s3_ready = !s3_valid || s4_ready;
  assign s2_ready = !s2_valid || s3_ready;
  assign s1_ready = !s1_valid || s2_ready;
  assign ready = s1_ready;
  assign out_valid = s4_valid;

  // Year arithmetic
  logic [15:0]        y;
  logic [15:0]        p;
  logic [9:0]         p_div100;
  logic [9:0]         p_div400;
  logic [14:0]        leaps;
  logic signed [16:0] year_rel;
  logic [9:0]         y_div100;
  logic [9:0]         y_div400;
  logic               div_by_4;
  logic               div_by_100;
  logic               div_by_400;
  logic [3:0]         month_done;

  always_comb begin
    y = s1.year;
    p = y - 16'd1;
    p_div100 = div25(p[15:2]);
    p_div400 = div25({2'd0, p[15:4]});
    if (y == 16'd0) begin
      leaps = 15'd0;
    end else begin
      leaps = {1'b0, p[15:2]} - {5'd0, p_div100} + {5'd0, p_div400} + 15'd1;
    end
    year_rel = $signed({1'b0, y}) - $signed({1'b0, EPOCH_YEAR});
    y_div100 = div25(y[15:2]);
    y_div400 = div25({2'd0, y[15:4]});
    div_by_4 = (y[1:0] == 2'd0);
    div_by_100 = div_by_4 && ({4'd0, y_div100} * 14'd25 == y[15:2]);
    div_by_400 = (y[3:0] == 4'd0) && ({2'd0, y_div400} * 12'd25 == y[15:4]);
    // Completed months, clamped to a full year
    if (s1.month == 8'd0) begin
      month_done = 4'd0;
    end else if (s1.month > 8'd13) begin
      month_done = 4'd12;
    end else begin
      month_done = 4'(s1.month - 8'd1);
    end
  end

  // Day count and time of day of stage 3
  logic signed [DAYS_W-1:0] days_sum;
  logic [HMS_W-1:0]         hms_sum;

  always_comb begin
    days_sum = s2_year_days + DAYS_W'(s2_leap_diff)
             + $signed({{(DAYS_W-9){1'b0}}, cum_days(s2_done)})
             + $signed({{(DAYS_W-1){1'b0}}, s2_leap_adj})
             + $signed({{(DAYS_W-8){1'b0}}, s2_day}) - DAYS_W'(1);
    hms_sum = {12'd0, s2_hour} * 20'd3600 + {12'd0, s2_minute} * 20'd60
            + {12'd0, s2_second};
  end

  // Advance the pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= load;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
      if (s3_ready) begin
        s3_valid <= s2_valid;
      end
      if (s4_ready) begin
        s4_valid <= s3_valid;
      end
    end
    if (s1_ready && load) begin
      s1 <= ts;
    end
    if (s2_ready && s1_valid) begin
      s2_year_days <= DAYS_W'(year_rel) * DAYS_W'(365);
      s2_leap_diff <= $signed({1'b0, leaps}) - LEAPS_BEFORE_EPOCH;
      s2_leap_adj  <= (s1.month > 8'd2) && div_by_4 && (!div_by_100 || div_by_400);
      s2_done      <= month_done;
      s2_day       <= s1.day;
      s2_hour      <= s1.hour;
      s2_minute    <= s1.minute;
      s2_second    <= s1.second;
    end
    if (s3_ready && s2_valid) begin
      s3_days <= days_sum;
      s3_hms  <= hms_sum;
    end
  end

  // Scale days to seconds in the result register
  always_ff @(posedge clk) begin
    if (s3_valid && s4_ready) begin
      epoch_seconds <= OUT_W'(s3_days) * OUT_W'(SECS_PER_DAY)
                     + $signed({{(OUT_W-HMS_W){1'b0}}, s3_hms});
    end
  end

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the frame timestamp to epoch seconds converter.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ftes_pkg::*;

  localparam int unsigned TIME_OFFSET = 10;
  localparam int unsigned FRAME_LEN = TIME_OFFSET + 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int END_DRAIN = 12;
  localparam int MONTH_DAYS [13] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334, 365};

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [7:0]              data_byte;
  logic                    frame_start;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [OUT_W-1:0] epoch_seconds;

  // Predictor state: byte position and captured timestamp bytes
  int unsigned frame_pos;
  ts_t         stamp;

  logic signed [OUT_W-1:0] epoch_queue [$];
  int errors;
  int cycles;
  int bytes_sent;
  bit quiet;
  int stall_left;

  frame_timestamp_to_epoch_seconds #(
    .TIME_OFFSET(TIME_OFFSET)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .data_byte(data_byte),
    .frame_start(frame_start),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .epoch_seconds(epoch_seconds)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Leap years in [0, y) for y >= 0
  function automatic longint leap_years_before(input longint y);
    longint p;
    if (y <= 0) begin
      return 0;
    end
    p = y - 1;
    return p / 4 - p / 100 + p / 400 + 1;
  endfunction

  function automatic bit is_leap_year(input longint y);
    return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
  endfunction

  // Seconds since 1970 for a captured timestamp, kept to the output width
  function automatic logic signed [OUT_W-1:0] epoch_of(input ts_t t);
    longint y;
    longint days;
    longint secs;
    int unsigned done;
    y = longint'(t.year);
    done = (t.month == 8'd0) ? 0 : t.month - 1;
    if (done > 12) begin
      done = 12;
    end
    days = (y - longint'(EPOCH_YEAR)) * 365;
    days += leap_years_before(y) - leap_years_before(longint'(EPOCH_YEAR));
    days += MONTH_DAYS[done];
    if (t.month > 8'd2 && is_leap_year(y)) begin
      days += 1;
    end
    days += longint'(t.day) - 1;
    secs = days * longint'(SECS_PER_DAY) + longint'(t.hour) * 3600
         + longint'(t.minute) * 60 + longint'(t.second);
    return secs[OUT_W-1:0];
  endfunction

  // Advance the predictor by one accepted byte
  task automatic track_byte(input logic [7:0] b, input logic s);
    int unsigned pos;
    if (s) begin
      frame_pos = 0;
    end
    pos = frame_pos;
    if (pos == TIME_OFFSET) begin
      stamp.year[15:8] = b;
    end else if (pos == TIME_OFFSET + 1) begin
      stamp.year[7:0] = b;
    end else if (pos == TIME_OFFSET + 2) begin
      stamp.month = b;
    end else if (pos == TIME_OFFSET + 3) begin
      stamp.day = b;
    end else if (pos == TIME_OFFSET + 5) begin
      stamp.hour = b;
    end else if (pos == TIME_OFFSET + 6) begin
      stamp.minute = b;
    end else if (pos == TIME_OFFSET + 7) begin
      stamp.second = b;
      epoch_queue.push_back(epoch_of(stamp));
    end
    if (pos < FRAME_LEN) begin
      frame_pos = pos + 1;
    end
  endtask

  // Send one byte, with an optional idle burst ahead of it
  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(3) == 0) begin
      gap = $urandom_range(4, 1);
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    data_byte = b;
    frame_start = s;
    do @(posedge clk); while (in_stall);
    track_byte(b, s);
    bytes_sent++;
  endtask

  // Build a frame carrying t with tail extra bytes after it, and send its first len bytes
  task automatic send_frame(input ts_t t, input int len, input int tail, input bit start);
    logic [7:0] bytes [$];
    int i;
    for (i = 0; i < TIME_OFFSET; i++) begin
      bytes.push_back(8'($urandom));
    end
    bytes.push_back(t.year[15:8]);
    bytes.push_back(t.year[7:0]);
    bytes.push_back(t.month);
    bytes.push_back(t.day);
    bytes.push_back(8'($urandom));
    bytes.push_back(t.hour);
    bytes.push_back(t.minute);
    bytes.push_back(t.second);
    for (i = 0; i < tail; i++) begin
      bytes.push_back(8'($urandom));
    end
    if (len > bytes.size()) begin
      len = bytes.size();
    end
    for (i = 0; i < len; i++) begin
      send_byte(bytes[i], start && i == 0);
    end
  endtask

  function automatic ts_t make_stamp(input int unsigned yr, input int unsigned mo,
                                     input int unsigned dy, input int unsigned hr,
                                     input int unsigned mi, input int unsigned se);
    ts_t t;
    t.year = 16'(yr);
    t.month = 8'(mo);
    t.day = 8'(dy);
    t.hour = 8'(hr);
    t.minute = 8'(mi);
    t.second = 8'(se);
    return t;
  endfunction

  // Mostly plausible timestamps, with a share of full-range bytes
  function automatic ts_t rand_stamp();
    ts_t t;
    case ($urandom_range(9))
      0, 1, 2, 3, 4, 5: t.year = 16'($urandom_range(2099, 1970));
      6:                t.year = 16'($urandom_range(1969, 1583));
      7:                t.year = 16'($urandom);
      8:                t.year = 16'($urandom_range(400));
      default:          t.year = 16'($urandom_range(65535, 65000));
    endcase
    t.month = ($urandom_range(4) != 0) ? 8'($urandom_range(12, 1)) : 8'($urandom);
    t.day = ($urandom_range(4) != 0) ? 8'($urandom_range(31, 1)) : 8'($urandom);
    t.hour = ($urandom_range(4) != 0) ? 8'($urandom_range(23)) : 8'($urandom);
    t.minute = ($urandom_range(4) != 0) ? 8'($urandom_range(59)) : 8'($urandom);
    t.second = ($urandom_range(4) != 0) ? 8'($urandom_range(59)) : 8'($urandom);
    return t;
  endfunction

  // Bytes before the first start flag count from position zero
  task automatic test_pre_start_bytes();
    send_frame(make_stamp(1970, 1, 1, 0, 0, 0), FRAME_LEN, 0, 1'b0);
  endtask

  // Field extremes, month clamping, day zero and leap handling
  task automatic test_field_extremes();
    send_frame(make_stamp(0, 0, 0, 0, 0, 0), FRAME_LEN, 0, 1'b1);
    send_frame(make_stamp(65535, 255, 255, 255, 255, 255), FRAME_LEN, 0, 1'b1);
    send_frame(make_stamp(2000, 2, 29, 23, 59, 59), FRAME_LEN, 0, 1'b1);
    send_frame(make_stamp(2000, 3, 1, 0, 0, 0), FRAME_LEN, 0, 1'b1);
    send_frame(make_stamp(1900, 3, 1, 12, 30, 30), FRAME_LEN, 0, 1'b1);
    send_frame(make_stamp(0, 3, 1, 0, 0, 0), FRAME_LEN, 0, 1'b1);
    send_frame(make_stamp(2023, 13, 1, 0, 0, 0), FRAME_LEN, 0, 1'b1);
    send_frame(make_stamp(2024, 12, 31, 23, 59, 59), FRAME_LEN, 0, 1'b1);
  endtask

  // Frames cut before the seconds byte give no result
  task automatic test_short_frames();
    send_frame(make_stamp(2010, 6, 15, 8, 0, 0), FRAME_LEN - 1, 0, 1'b1);
    send_frame(make_stamp(2011, 7, 16, 9, 1, 1), 3, 0, 1'b1);
  endtask

  // Position hold after the seconds byte; the tail lies beyond len, so only the frame itself is sent
  task automatic test_position_saturation();
    send_frame(make_stamp(1999, 12, 31, 23, 59, 58), FRAME_LEN, 2 * FRAME_LEN, 1'b1);
  endtask

  // Well-formed frames with random content, mixed with cut and noisy ones
  task automatic test_random_frames();
    int pick;
    while (bytes_sent < 550 - 4 * FRAME_LEN) begin
      pick = $urandom_range(9);
      if (pick < 8) begin
        send_frame(rand_stamp(), FRAME_LEN, $urandom_range(3), 1'b1);
      end else if (pick == 8) begin
        send_frame(rand_stamp(), $urandom_range(FRAME_LEN - 1, 1), 0, 1'b1);
      end else begin
        repeat ($urandom_range(20, 1)) begin
          send_byte(8'($urandom), $urandom_range(7) == 0);
        end
      end
    end
  endtask

  // Close with back-to-back frames and no idling on either side
  task automatic test_full_rate();
    quiet = 1'b1;
    repeat (4) begin
      send_frame(rand_stamp(), FRAME_LEN, 0, 1'b1);
    end
  endtask

  // Random output stall bursts, driven on the falling edge
  always @(negedge clk) begin
    if (rst || quiet) begin
      out_stall = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall = 1'b1;
    end else if ($urandom_range(3) == 0) begin
      stall_left = $urandom_range(4, 1) - 1;
      out_stall = 1'b1;
    end else begin
      out_stall = 1'b0;
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (epoch_queue.size() == 0) begin
        $error("epoch_seconds: expected none, actual %0d", epoch_seconds);
        errors++;
      end else if (epoch_seconds !== epoch_queue[0]) begin
        $error("epoch_seconds: expected %0d, actual %0d", epoch_queue[0], epoch_seconds);
        errors++;
        void'(epoch_queue.pop_front());
      end else begin
        void'(epoch_queue.pop_front());
      end
    end
  end

  // Stop a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("frame_timestamp_to_epoch_seconds verification failed");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    data_byte = 8'd0;
    frame_start = 1'b0;
    out_stall = 1'b0;
    errors = 0;
    cycles = 0;
    bytes_sent = 0;
    quiet = 1'b0;
    stall_left = 0;
    frame_pos = 0;
    stamp = '0;
    repeat (10) @(negedge clk);
    rst = 1'b0;

    test_pre_start_bytes();
    test_field_extremes();
    test_short_frames();
    test_position_saturation();
    test_random_frames();
    test_full_rate();

    @(negedge clk);
    in_valid = 1'b0;
    while (epoch_queue.size() != 0) begin
      @(posedge clk);
    end
    repeat (END_DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("frame_timestamp_to_epoch_seconds verification clean");
    end else begin
      $display("frame_timestamp_to_epoch_seconds verification failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/ftes_pkg.sv
rtl/ftes_calc.sv
rtl/frame_timestamp_to_epoch_seconds.sv
tb/sv/tb.sv
